>>> hdl/ikc_pkg.sv
// ----------------------------------------------------------------------------
// ikc_pkg : shared types and constants for the imu tilt filter
// Number formats, the cordic arctangent table, register codes, the state
// encoding and the command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package ikc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TAB_FRAC  = 24;
	localparam int TAB_LEN   = 24;
	localparam int ITER_W    = 5;
	localparam int DIV_BITS  = FRAC_BITS + 32;

	// +-180 degrees in Q16.16
	localparam logic signed [24:0] ANG_MAX = 25'sd11796480;
	localparam logic [16:0]        ONE     = 17'd65536;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	typedef enum logic [2:0] {
		CFG_Q_ANGLE    = 3'd0,
		CFG_Q_BIAS     = 3'd1,
		CFG_R_NOISE    = 3'd2,
		CFG_COMP_ALPHA = 3'd3,
		CFG_GYRO_SCALE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] q_angle;
		logic [15:0] q_bias;
		logic [15:0] r_noise;
		logic [16:0] comp_alpha;
		logic [15:0] gyro_scale;
	} cfg_t;

	// operand pairs for the shared multiplier
	typedef enum logic [3:0] {
		MUL_NONE, MUL_GS, MUL_RDT, MUL_AG, MUL_BA, MUL_DRB, MUL_DP3, MUL_DU,
		MUL_QB, MUL_K0I, MUL_K1I, MUL_K1P0, MUL_K1P1, MUL_K0P0, MUL_K0P1
	} mul_sel_t;

	// what the datapath does with the registered product
	typedef enum logic [4:0] {
		WB_NONE, WB_RATE, WB_GYR, WB_SUM, WB_COMP, WB_KPRED, WB_DP3, WB_U,
		WB_P0, WB_P3, WB_INNOV, WB_KUPD, WB_BUPD, WB_P2, WB_P3U, WB_P0U,
		WB_P1U, WB_FUSE
	} wb_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CORD, ST_ACC, ST_RATE, ST_M_RDT, ST_GYR, ST_M_AG, ST_M_BA,
		ST_COMP, ST_KPRED, ST_DP3, ST_U, ST_M_DU, ST_P0, ST_P3, ST_S, ST_DIV,
		ST_M_K0I, ST_KUPD, ST_BUPD, ST_P2, ST_P3B, ST_P0B, ST_P1B, ST_FUSE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              load;
		logic              cord_step;
		logic [ITER_W-1:0] iter;
		logic              cord_fin;
		mul_sel_t          mul_sel;
		wb_sel_t           wb_sel;
		logic              div_start;
		logic              k_zero;
		logic              k_load;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic s_pos;
		logic div_done;
	} sts_t;

endpackage

>>> hdl/imu_tilt_kalman_complementary.sv
// ----------------------------------------------------------------------------
// imu_tilt_kalman_complementary : imu tilt angle from accelerometer and gyro
// Cordic tilt, gyro integration, complementary filter and a two-state
// angle/bias kalman filter; the fused angle feeds the next sample.
//
//   channel | direction | signals
//   --------+-----------+---------------------------------------------------
//   in      | sink      | in_valid/in_ready, accel_x, accel_z, gyro_y, delta_t
//   out     | source    | out_valid/out_ready, five angles, bias_estimate
//   cfg     | sink      | cfg_valid/cfg_ready, cfg_index, cfg_data
//
// a result waits on the 48-step gain divider only when P00 + r_noise is
// positive; otherwise the divider is skipped and the gains stay zero. the
// sequencer returns to idle as the result enters the output register, so a
// new word can be taken while that result waits there; the next result is
// held back until the output register is free. reset clears the filter
// state and loads the default registers; cfg writes are always taken.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_complementary #(
	parameter int CORDIC_ITERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_y,
	input  logic [16:0]        delta_t,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [24:0] acc_tilt,
	output logic signed [24:0] gyro_tilt,
	output logic signed [24:0] comp_angle,
	output logic signed [24:0] kalman_angle,
	output logic signed [24:0] fused_angle,
	output logic signed [31:0] bias_estimate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import ikc_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.q_angle    <= 16'd66;
			cfg_q.q_bias     <= 16'd197;
			cfg_q.r_noise    <= 16'd1966;
			cfg_q.comp_alpha <= 17'd64225;
			cfg_q.gyro_scale <= 16'd1001;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_Q_ANGLE:    cfg_q.q_angle    <= cfg_data[15:0];
				CFG_Q_BIAS:     cfg_q.q_bias     <= cfg_data[15:0];
				CFG_R_NOISE:    cfg_q.r_noise    <= cfg_data[15:0];
				CFG_COMP_ALPHA: cfg_q.comp_alpha <= cfg_data;
				CFG_GYRO_SCALE: cfg_q.gyro_scale <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ikc_ctrl #(
		.CORDIC_ITERS (CORDIC_ITERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ikc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.accel_x       (accel_x),
		.accel_z       (accel_z),
		.gyro_y        (gyro_y),
		.delta_t       (delta_t),
		.cmd           (cmd),
		.sts           (sts),
		.acc_tilt      (acc_tilt),
		.gyro_tilt     (gyro_tilt),
		.comp_angle    (comp_angle),
		.kalman_angle  (kalman_angle),
		.fused_angle   (fused_angle),
		.bias_estimate (bias_estimate)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a word was accepted");

	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (acc_tilt <= ANG_MAX) && (acc_tilt >= -ANG_MAX))
		else $error("accel angle beyond 180 degrees");

	a_fused_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fused_angle <= ANG_MAX) && (fused_angle >= -ANG_MAX))
		else $error("fused angle beyond 180 degrees");

endmodule

>>> hdl/ikc_div.sv
// ----------------------------------------------------------------------------
// ikc_div : two-lane restoring divider for the kalman gains
// Divides P00<<16 and P10<<16 by one positive divisor, one quotient bit per
// cycle, and saturates both quotients to 32 bits signed.
// ----------------------------------------------------------------------------
module ikc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num0,
	input  logic signed [31:0] num1,
	input  logic [31:0]        den,
	output logic               done,
	output logic signed [31:0] quo0,
	output logic signed [31:0] quo1
);
	import ikc_pkg::*;

	localparam int CntW = $clog2(DIV_BITS);

	logic                run_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [31:0]         den_q;
	logic [31:0]         rem0_q, rem1_q;
	logic [DIV_BITS-1:0] dvd0_q, dvd1_q;
	logic                neg0_q, neg1_q;
	logic [31+DIV_BITS:0] step0, step1;

	function automatic logic [31+DIV_BITS:0] lane_step(input logic [31:0] rem,
			input logic [DIV_BITS-1:0] dvd, input logic [31:0] d);
		logic [32:0] r2;
		logic        ge;
		r2 = {rem, dvd[DIV_BITS-1]};
		ge = (r2 >= {1'b0, d});
		return {(ge ? 32'(r2 - {1'b0, d}) : r2[31:0]), dvd[DIV_BITS-2:0], ge};
	endfunction

	function automatic logic [31:0] mag(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [31:0] sat_q(input logic neg,
			input logic [DIV_BITS-1:0] q);
		if (!neg) begin
			return (q > DIV_BITS'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
		end
		return (q > DIV_BITS'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
	endfunction

	assign step0 = lane_step(rem0_q, dvd0_q, den_q);
	assign step1 = lane_step(rem1_q, dvd1_q, den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DIV_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem0_q <= '0;
			rem1_q <= '0;
			dvd0_q <= {mag(num0), FRAC_BITS'(0)};
			dvd1_q <= {mag(num1), FRAC_BITS'(0)};
			neg0_q <= num0[31];
			neg1_q <= num1[31];
		end else if (run_q) begin
			{rem0_q, dvd0_q} <= step0;
			{rem1_q, dvd1_q} <= step1;
		end
	end

	assign done = done_q;
	assign quo0 = sat_q(neg0_q, dvd0_q);
	assign quo1 = sat_q(neg1_q, dvd1_q);

endmodule

>>> hdl/ikc_dp.sv
// ----------------------------------------------------------------------------
// ikc_dp : datapath of the imu tilt filter
// Cordic arctangent, one shared registered multiplier with rounding and
// saturation, the filter state, the gain divider and the result registers.
// ----------------------------------------------------------------------------
module ikc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ikc_pkg::cfg_t      cfg,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_y,
	input  logic [16:0]        delta_t,
	input  ikc_pkg::cmd_t      cmd,
	output ikc_pkg::sts_t      sts,
	output logic signed [24:0] acc_tilt,
	output logic signed [24:0] gyro_tilt,
	output logic signed [24:0] comp_angle,
	output logic signed [24:0] kalman_angle,
	output logic signed [24:0] fused_angle,
	output logic signed [31:0] bias_estimate
);
	import ikc_pkg::*;

	localparam logic signed [55:0] S32_MAX = 56'sd2147483647;
	localparam logic signed [55:0] S32_MIN = -56'sd2147483648;
	localparam logic signed [34:0] Z180    = 35'sd3019898880;

	function automatic logic signed [68-FRAC_BITS:0] rnd_q(input logic signed [68:0] v);
		logic [68:0] t;
		t = v + (69'd1 << (FRAC_BITS - 1)) - 69'(v[68]);
		return $signed(t[68:FRAC_BITS]);
	endfunction

	function automatic logic signed [24:0] sat_ang(input logic signed [55:0] v);
		if (v > 56'(ANG_MAX)) return ANG_MAX;
		if (v < -56'(ANG_MAX)) return -ANG_MAX;
		return v[24:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		if (v > S32_MAX) return S32_MAX[31:0];
		if (v < S32_MIN) return S32_MIN[31:0];
		return v[31:0];
	endfunction

	// sample and cordic
	logic signed [15:0] ax_q, az_q, gy_q;
	logic [16:0]        dt_q;
	logic signed [34:0] x_q, y_q, z_q;
	// per-sample intermediates
	logic signed [24:0] acc_q, gyr_q, comp_q;
	logic signed [31:0] rate_q, innov_q, k0_q, k1_q;
	logic signed [67:0] prod_q, sum_q;
	logic signed [33:0] dp3_q;
	logic signed [34:0] u_q;
	// filter state
	logic signed [24:0] prev_q, kal_q;
	logic signed [31:0] bias_q, p00_q, p01_q, p10_q, p11_q;
	// result word
	logic signed [24:0] acc_o_q, gyr_o_q, comp_o_q, kal_o_q, fused_o_q;
	logic signed [31:0] bias_o_q;

	logic [16:0]        alpha, oma;
	logic signed [32:0] alpha_s, oma_s, dt_s;
	logic signed [34:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [67:0] prod_d;
	logic signed [68-FRAC_BITS:0] rnd;
	logic signed [34:0] dx, dy, atan_v, zt;
	logic signed [34:0] x0, y0;
	logic signed [32:0] s_sum;
	logic signed [25:0] fsum, ft;
	logic               div_done;
	logic signed [31:0] q0, q1;

	assign alpha   = (cfg.comp_alpha > ONE) ? ONE : cfg.comp_alpha;
	assign oma     = ONE - alpha;
	assign alpha_s = $signed({16'd0, alpha});
	assign oma_s   = $signed({16'd0, oma});
	assign dt_s    = $signed({16'd0, dt_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_GS: begin
				mul_a = 35'(gy_q);
				mul_b = $signed({17'd0, cfg.gyro_scale});
			end
			MUL_RDT: begin
				mul_a = 35'(rate_q);
				mul_b = dt_s;
			end
			MUL_AG: begin
				mul_a = 35'(gyr_q);
				mul_b = alpha_s;
			end
			MUL_BA: begin
				mul_a = 35'(acc_q);
				mul_b = oma_s;
			end
			MUL_DRB: begin
				mul_a = 35'(rate_q) - 35'(bias_q);
				mul_b = dt_s;
			end
			MUL_DP3: begin
				mul_a = 35'(p11_q);
				mul_b = dt_s;
			end
			MUL_DU: begin
				mul_a = u_q;
				mul_b = dt_s;
			end
			MUL_QB: begin
				mul_a = $signed({19'd0, cfg.q_bias});
				mul_b = dt_s;
			end
			MUL_K0I: begin
				mul_a = 35'(innov_q);
				mul_b = 33'(k0_q);
			end
			MUL_K1I: begin
				mul_a = 35'(innov_q);
				mul_b = 33'(k1_q);
			end
			MUL_K1P0: begin
				mul_a = 35'(p00_q);
				mul_b = 33'(k1_q);
			end
			MUL_K1P1: begin
				mul_a = 35'(p01_q);
				mul_b = 33'(k1_q);
			end
			MUL_K0P0: begin
				mul_a = 35'(p00_q);
				mul_b = 33'(k0_q);
			end
			MUL_K0P1: begin
				mul_a = 35'(p01_q);
				mul_b = 33'(k0_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;
	assign rnd    = rnd_q(69'(prod_q));

	// one cordic micro-rotation
	assign dx     = y_q >>> cmd.iter;
	assign dy     = x_q >>> cmd.iter;
	assign atan_v = $signed({3'd0, ATAN_TAB[cmd.iter]});
	assign zt     = z_q + (35'sd1 <<< (TAB_FRAC - FRAC_BITS - 1)) - 35'(z_q[34]);
	assign x0     = 35'($signed({accel_z, 16'd0}));
	assign y0     = 35'($signed({accel_x, 16'd0}));

	assign s_sum  = 33'(p00_q) + $signed({17'd0, cfg.r_noise});
	assign fsum   = 26'(comp_q) + 26'(kal_q);
	assign ft     = fsum + 26'sd1 - 26'(fsum[25]);

	assign sts.s_pos    = !s_sum[32] && (s_sum != '0);
	assign sts.div_done = div_done;

	ikc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num0   (p00_q),
		.num1   (p10_q),
		.den    (s_sum[31:0]),
		.done   (div_done),
		.quo0   (q0),
		.quo1   (q1)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= accel_x;
			az_q <= accel_z;
			gy_q <= gyro_y;
			dt_q <= delta_t;
			x_q  <= accel_z[15] ? -x0 : x0;
			y_q  <= accel_z[15] ? -y0 : y0;
			z_q  <= accel_z[15] ? (accel_x > 16'sd0 ? Z180 : -Z180) : 35'sd0;
		end else if (cmd.cord_step) begin
			if (y_q > 35'sd0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end
		end
		if (cmd.cord_fin) begin
			if (ax_q == 16'sd0) begin
				acc_q <= az_q[15] ? ANG_MAX : 25'sd0;
			end else begin
				acc_q <= sat_ang(56'($signed(zt[34:TAB_FRAC-FRAC_BITS])));
			end
		end
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= prod_d;
		end
		if (cmd.k_zero) begin
			k0_q <= '0;
			k1_q <= '0;
		end else if (cmd.k_load) begin
			k0_q <= q0;
			k1_q <= q1;
		end
		case (cmd.wb_sel)
			WB_RATE:  rate_q  <= prod_q[31:0];
			WB_GYR:   gyr_q   <= sat_ang(56'(prev_q) + 56'(rnd));
			WB_SUM:   sum_q   <= prod_q;
			WB_COMP:  comp_q  <= sat_ang(56'(rnd_q(69'(sum_q) + 69'(prod_q))));
			WB_DP3:   dp3_q   <= rnd[33:0];
			WB_U:     u_q     <= 35'(dp3_q) - 35'(p01_q) - 35'(p10_q)
				+ $signed({19'd0, cfg.q_angle});
			WB_INNOV: innov_q <= sat32(56'(acc_q) - 56'(kal_q));
			default: ;
		endcase
		if (cmd.out_load) begin
			acc_o_q   <= acc_q;
			gyr_o_q   <= gyr_q;
			comp_o_q  <= comp_q;
			kal_o_q   <= kal_q;
			fused_o_q <= prev_q;
			bias_o_q  <= bias_q;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			kal_q  <= '0;
			bias_q <= '0;
			p00_q  <= '0;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= '0;
		end else begin
			case (cmd.wb_sel)
				WB_KPRED: kal_q  <= sat_ang(56'(kal_q) + 56'(rnd));
				WB_U: begin
					p01_q <= sat32(56'(p01_q) - 56'(dp3_q));
					p10_q <= sat32(56'(p10_q) - 56'(dp3_q));
				end
				WB_P0:    p00_q  <= sat32(56'(p00_q) + 56'(rnd));
				WB_P3:    p11_q  <= sat32(56'(p11_q) + 56'(rnd));
				WB_KUPD:  kal_q  <= sat_ang(56'(kal_q) + 56'(rnd));
				WB_BUPD:  bias_q <= sat32(56'(bias_q) + 56'(rnd));
				WB_P2:    p10_q  <= sat32(56'(p10_q) - 56'(rnd));
				WB_P3U:   p11_q  <= sat32(56'(p11_q) - 56'(rnd));
				WB_P0U:   p00_q  <= sat32(56'(p00_q) - 56'(rnd));
				WB_P1U:   p01_q  <= sat32(56'(p01_q) - 56'(rnd));
				WB_FUSE:  prev_q <= ft[25:1];
				default: ;
			endcase
		end
	end

	assign acc_tilt      = acc_o_q;
	assign gyro_tilt     = gyr_o_q;
	assign comp_angle    = comp_o_q;
	assign kalman_angle  = kal_o_q;
	assign fused_angle   = fused_o_q;
	assign bias_estimate = bias_o_q;

endmodule

>>> hdl/ikc_ctrl.sv
// ----------------------------------------------------------------------------
// ikc_ctrl : sequencer of the imu tilt filter
// Steps the datapath through cordic, prediction, gain division and update,
// and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module ikc_ctrl #(
	parameter int CORDIC_ITERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ikc_pkg::sts_t sts,
	output ikc_pkg::cmd_t cmd
);
	import ikc_pkg::*;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              slot_free;
	logic              last_iter;

	assign slot_free = !out_valid_q || out_ready;
	assign last_iter = (iter_q == ITER_W'(CORDIC_ITERS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CORD;
			ST_CORD:  if (last_iter) state_d = ST_ACC;
			ST_ACC:   state_d = ST_RATE;
			ST_RATE:  state_d = ST_M_RDT;
			ST_M_RDT: state_d = ST_GYR;
			ST_GYR:   state_d = ST_M_AG;
			ST_M_AG:  state_d = ST_M_BA;
			ST_M_BA:  state_d = ST_COMP;
			ST_COMP:  state_d = ST_KPRED;
			ST_KPRED: state_d = ST_DP3;
			ST_DP3:   state_d = ST_U;
			ST_U:     state_d = ST_M_DU;
			ST_M_DU:  state_d = ST_P0;
			ST_P0:    state_d = ST_P3;
			ST_P3:    state_d = ST_S;
			ST_S:     state_d = sts.s_pos ? ST_DIV : ST_M_K0I;
			ST_DIV:   if (sts.div_done) state_d = ST_M_K0I;
			ST_M_K0I: state_d = ST_KUPD;
			ST_KUPD:  state_d = ST_BUPD;
			ST_BUPD:  state_d = ST_P2;
			ST_P2:    state_d = ST_P3B;
			ST_P3B:   state_d = ST_P0B;
			ST_P0B:   state_d = ST_P1B;
			ST_P1B:   state_d = ST_FUSE;
			ST_FUSE:  state_d = ST_DONE;
			ST_DONE:  if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MUL_NONE;
		cmd.wb_sel    = WB_NONE;
		cmd.iter      = iter_q;
		case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_CORD:  cmd.cord_step = 1'b1;
			ST_ACC: begin
				cmd.cord_fin = 1'b1;
				cmd.mul_sel  = MUL_GS;
			end
			ST_RATE:  cmd.wb_sel = WB_RATE;
			ST_M_RDT: cmd.mul_sel = MUL_RDT;
			ST_GYR:   cmd.wb_sel = WB_GYR;
			ST_M_AG:  cmd.mul_sel = MUL_AG;
			ST_M_BA: begin
				cmd.wb_sel  = WB_SUM;
				cmd.mul_sel = MUL_BA;
			end
			ST_COMP: begin
				cmd.wb_sel  = WB_COMP;
				cmd.mul_sel = MUL_DRB;
			end
			ST_KPRED: begin
				cmd.wb_sel  = WB_KPRED;
				cmd.mul_sel = MUL_DP3;
			end
			ST_DP3:   cmd.wb_sel = WB_DP3;
			ST_U:     cmd.wb_sel = WB_U;
			ST_M_DU:  cmd.mul_sel = MUL_DU;
			ST_P0: begin
				cmd.wb_sel  = WB_P0;
				cmd.mul_sel = MUL_QB;
			end
			ST_P3:    cmd.wb_sel = WB_P3;
			ST_S: begin
				// gains stay zero when the innovation variance is not positive
				cmd.wb_sel    = WB_INNOV;
				cmd.k_zero    = 1'b1;
				cmd.div_start = sts.s_pos;
			end
			ST_DIV:   cmd.k_load = sts.div_done;
			ST_M_K0I: cmd.mul_sel = MUL_K0I;
			ST_KUPD: begin
				cmd.wb_sel  = WB_KUPD;
				cmd.mul_sel = MUL_K1I;
			end
			ST_BUPD: begin
				cmd.wb_sel  = WB_BUPD;
				cmd.mul_sel = MUL_K1P0;
			end
			ST_P2: begin
				cmd.wb_sel  = WB_P2;
				cmd.mul_sel = MUL_K1P1;
			end
			ST_P3B: begin
				cmd.wb_sel  = WB_P3U;
				cmd.mul_sel = MUL_K0P0;
			end
			ST_P0B: begin
				cmd.wb_sel  = WB_P0U;
				cmd.mul_sel = MUL_K0P1;
			end
			ST_P1B:   cmd.wb_sel = WB_P1U;
			ST_FUSE:  cmd.wb_sel = WB_FUSE;
			ST_DONE:  cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				iter_q <= '0;
			end else if (state_q == ST_CORD) begin
				iter_q <= iter_q + 1'b1;
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sim/imu_tilt_kalman_complementary_tb.sv
// ----------------------------------------------------------------------------
// imu_tilt_kalman_complementary_tb : self-checking bench for the tilt filter
// Drives imu samples and register writes over valid/ready, predicts every
// result word with an in-bench fixed-point model of the filter and compares
// it field by field; both sides idle at random and the receiver stalls long.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_complementary_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ikc_pkg::*;

	localparam int           ITERS      = 16;
	localparam longint       QONE       = 64'sd65536;
	localparam longint       QANG       = 64'sd11796480;
	localparam longint       QMAX32     = 64'sd2147483647;
	localparam longint       QMIN32     = -64'sd2147483648;
	localparam logic [2:0]   CFG_UNUSED = 3'd5;
	localparam int           LIMIT      = 1500000;

	typedef struct {
		logic signed [24:0] acc;
		logic signed [24:0] gyr;
		logic signed [24:0] comp;
		logic signed [24:0] kal;
		logic signed [24:0] fused;
		logic signed [31:0] bias;
	} tilt_t;

	logic               clk, arst_n;
	logic               in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [15:0] accel_x, accel_z, gyro_y;
	logic [16:0]        delta_t;
	logic signed [24:0] acc_tilt, gyro_tilt, comp_angle, kalman_angle, fused_angle;
	logic signed [31:0] bias_estimate;
	logic [2:0]         cfg_index;
	logic [16:0]        cfg_data;

	// model state
	logic [15:0] m_qa, m_qb, m_r, m_gs;
	logic [16:0] m_alpha;
	longint      m_fused, m_kest, m_bias;
	longint      m_p [4];

	tilt_t  tilt_q [$];
	int     n_err;
	int     cycles;
	bit     quiet;
	int     hold_len;

	imu_tilt_kalman_complementary #(.CORDIC_ITERS(ITERS)) u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint rnd_shr(longint v, int n);
		longint m, h;
		m = (v < 0) ? -v : v;
		h = (n > 0) ? (64'sd1 <<< (n - 1)) : 0;
		m = (m + h) >>> n;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clip32(longint v);
		if (v > QMAX32) return QMAX32;
		if (v < QMIN32) return QMIN32;
		return v;
	endfunction

	function automatic longint clip_ang(longint v);
		if (v > QANG) v = QANG;
		if (v < -QANG) v = -QANG;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return rnd_shr(a * b, 16);
	endfunction

	function automatic longint tilt_deg(longint ax, longint az);
		longint x, y, z, dx, dy;
		z = 0;
		if (ax == 0) return (az >= 0) ? 0 : QANG;
		x = az * 65536;
		y = ax * 65536;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = (ax > 0) ? (64'sd180 <<< 24) : -(64'sd180 <<< 24);
		end
		for (int i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end
		end
		return clip_ang(rnd_shr(z, 8));
	endfunction

	function automatic void model_reset();
		m_qa = 16'd66; m_qb = 16'd197; m_r = 16'd1966;
		m_alpha = 17'd64225; m_gs = 16'd1001;
		m_fused = 0; m_kest = 0; m_bias = 0;
		for (int i = 0; i < 4; i++) m_p[i] = 0;
	endfunction

	function automatic void model_write(logic [2:0] idx, logic [16:0] d);
		case (idx)
			CFG_Q_ANGLE:    m_qa = d[15:0];
			CFG_Q_BIAS:     m_qb = d[15:0];
			CFG_R_NOISE:    m_r = d[15:0];
			CFG_COMP_ALPHA: m_alpha = d;
			CFG_GYRO_SCALE: m_gs = d[15:0];
			default: ;
		endcase
	endfunction

	function automatic tilt_t filter_step(logic signed [15:0] ax, logic signed [15:0] az,
			logic signed [15:0] gy, logic [16:0] dt_in);
		tilt_t  o;
		longint dt, alpha, acc, gyr, comp, rate, s, k0, k1, innov, p00, p01;
		dt = longint'(dt_in);
		alpha = (longint'(m_alpha) > QONE) ? QONE : longint'(m_alpha);
		k0 = 0;
		k1 = 0;
		acc = tilt_deg(longint'(ax), longint'(az));
		rate = longint'(gy) * longint'(m_gs);
		gyr = clip_ang(m_fused + qmul(rate, dt));
		comp = clip_ang(rnd_shr(alpha * gyr + (QONE - alpha) * acc, 16));
		m_kest = clip_ang(m_kest + qmul(dt, rate - m_bias));
		m_p[0] = clip32(m_p[0]
			+ qmul(dt, qmul(dt, m_p[3]) - m_p[1] - m_p[2] + longint'(m_qa)));
		m_p[1] = clip32(m_p[1] - qmul(dt, m_p[3]));
		m_p[2] = clip32(m_p[2] - qmul(dt, m_p[3]));
		m_p[3] = clip32(m_p[3] + qmul(longint'(m_qb), dt));
		s = m_p[0] + longint'(m_r);
		if (s > 0) begin
			k0 = clip32((m_p[0] * QONE) / s);
			k1 = clip32((m_p[2] * QONE) / s);
		end
		innov = clip32(acc - m_kest);
		m_kest = clip_ang(m_kest + qmul(k0, innov));
		m_bias = clip32(m_bias + qmul(k1, innov));
		p00 = m_p[0];
		p01 = m_p[1];
		m_p[0] = clip32(m_p[0] - qmul(k0, p00));
		m_p[1] = clip32(m_p[1] - qmul(k0, p01));
		m_p[2] = clip32(m_p[2] - qmul(k1, p00));
		m_p[3] = clip32(m_p[3] - qmul(k1, p01));
		m_fused = clip_ang(rnd_shr(comp + m_kest, 1));
		o.acc = acc[24:0]; o.gyr = gyr[24:0]; o.comp = comp[24:0];
		o.kal = m_kest[24:0]; o.fused = m_fused[24:0]; o.bias = m_bias[31:0];
		return o;
	endfunction

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random idling, optional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len = hold_len - 1;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
		end
	end

	// result checker
	always @(posedge clk) begin
		tilt_t e;
		if (arst_n && out_valid && out_ready) begin
			if (tilt_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result word at %0t", $realtime);
			end else begin
				e = tilt_q.pop_front();
				if (e.acc !== acc_tilt || e.gyr !== gyro_tilt || e.comp !== comp_angle ||
						e.kal !== kalman_angle || e.fused !== fused_angle ||
						e.bias !== bias_estimate) begin
					n_err++;
					if (n_err <= 10)
						$display({"mismatch: exp acc %0d gyr %0d comp %0d kal %0d fus %0d",
							" bias %0d / got %0d %0d %0d %0d %0d %0d"},
							e.acc, e.gyr, e.comp, e.kal, e.fused, e.bias, acc_tilt,
							gyro_tilt, comp_angle, kalman_angle, fused_angle, bias_estimate);
				end
			end
		end
	end

	task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] az,
			logic signed [15:0] gy, logic [16:0] dt);
		while (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= ax; accel_z <= az; gyro_y <= gy; delta_t <= dt;
		do @(posedge clk); while (!in_ready);
		tilt_q.push_back(filter_step(ax, az, gy, dt));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tilt_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [16:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		model_write(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(bit tame);
		logic signed [15:0] ax, az, gy;
		logic [16:0]        dt;
		ax = 16'($urandom); az = 16'($urandom); gy = 16'($urandom);
		dt = 17'($urandom_range(131071));
		if (tame) begin
			// realistic sensor: gravity mostly on z, small rate and step
			ax = 16'($signed($urandom_range(8000)) - 4000);
			az = 16'($signed($urandom_range(20000)) - 4000);
			gy = 16'($signed($urandom_range(2000)) - 1000);
			dt = 17'($urandom_range(2000));
		end else if (dt > 17'd65536) begin
			dt = $urandom_range(1) ? 17'd65536 : 17'($urandom_range(65536));
		end
		send_sample(ax, az, gy, dt);
	endtask

	task automatic test_directed();
		// zero innovation variance: P00 and r both zero
		write_reg(CFG_Q_ANGLE, 17'd0);
		write_reg(CFG_R_NOISE, 17'd0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 17'd0);
		send_sample(16'sd100, 16'sd1000, 16'sd10, 17'd0);
		settle();
		write_reg(CFG_Q_ANGLE, 17'd66);
		write_reg(CFG_R_NOISE, 17'd1966);
		// x axis zero, either sign of z
		send_sample(16'sd0, 16'sd500, 16'sd0, 17'd655);
		send_sample(16'sd0, -16'sd500, 16'sd0, 17'd655);
		send_sample(16'sd0, -16'sd32768, 16'sd0, 17'd655);
		// field extremes
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 17'd65536);
		send_sample(16'sd32767, -16'sd32768, 16'sd32767, 17'd65536);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767, 17'd65536);
		send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 17'd0);
		send_sample(16'sd1, -16'sd1, 16'sd32767, 17'd131071);
		send_sample(-16'sd1, -16'sd1, -16'sd32768, 17'd65535);
		settle();
		// alpha at and above one, plus the unused register index
		write_reg(CFG_COMP_ALPHA, 17'd65536);
		send_sample(16'sd3000, 16'sd9000, 16'sd200, 17'd1000);
		settle();
		write_reg(CFG_UNUSED, 17'h1ffff);
		write_reg(CFG_COMP_ALPHA, 17'h1ffff);
		send_sample(-16'sd3000, 16'sd9000, -16'sd200, 17'd1000);
		settle();
		write_reg(CFG_COMP_ALPHA, 17'd0);
		write_reg(CFG_Q_BIAS, 17'hffff);
		write_reg(CFG_GYRO_SCALE, 17'hffff);
		send_sample(16'sd12000, -16'sd200, 16'sd32767, 17'd65536);
		send_sample(-16'sd12000, -16'sd200, -16'sd32768, 17'd65536);
		settle();
	endtask

	task automatic test_random_settings();
		logic [16:0] v;
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 5; r++) begin
				case ($urandom_range(3))
					0: v = (r == 2 || r == 4) ? 17'd1 : 17'd0;
					1: v = (r == 3) ? 17'd65536 : 17'hffff;
					2: v = 17'($urandom);
					default: v = (r == 3) ? 17'($urandom_range(65536))
						: 17'($urandom_range(2000));
				endcase
				if (ph == 0) v = (r == 3) ? 17'd64225 : v;
				write_reg(3'(r), (r == 3) ? v : {1'b0, v[15:0]});
			end
			quiet = (ph == 2);
			for (int n = 0; n < 170; n++) send_random($urandom_range(99) < 70);
			quiet = 1'b0;
			settle();
		end
	endtask

	task automatic test_output_stall();
		hold_len = 600;
		for (int n = 0; n < 40; n++) send_random(1'b1);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; cfg_valid = 1'b0; out_ready = 1'b0;
		accel_x = '0; accel_z = '0; gyro_y = '0; delta_t = '0;
		cfg_index = '0; cfg_data = '0;
		n_err = 0; cycles = 0; quiet = 1'b0; hold_len = 0;
		model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_stall();
		test_random_settings();
		settle();
		if (n_err == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
